// ----- src/tcpq_pkg.sv -----
package tcpq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int ID_WIDTH      = 16;
  localparam int LIMIT_WIDTH   = 5;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(5);

  localparam logic CLASS_ORDINARY = 1'b0;
  localparam logic CLASS_PRIORITY = 1'b1;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_SERVE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ADMITTED    = 2'd0,
    ST_TURNED_AWAY = 2'd1,
    ST_SERVED      = 2'd2,
    ST_EMPTY       = 2'd3
  } status_t;

  typedef struct packed {
    op_t  operation;
    logic client_class;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [ID_WIDTH-1:0] client_id;
    logic                served_class;
  } out_item_t;

  // per-queue command from the top level to a chain
  typedef struct packed {
    logic push;
    logic pop;
  } chain_ctrl_t;

endpackage

// ----- src/tcpq_cell.sv -----
module tcpq_cell (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          shift,
  input  logic [tcpq_pkg::ID_WIDTH-1:0] push_id,
  input  logic [tcpq_pkg::ID_WIDTH-1:0] nbr_id,
  output logic [tcpq_pkg::ID_WIDTH-1:0] id
);
  import tcpq_pkg::*;

  logic [ID_WIDTH-1:0] id_r;

  // load takes the arriving id, shift takes the right neighbor's id
  always_ff @(posedge clk) begin
    if (load) begin
      id_r <= push_id;
    end else if (shift) begin
      id_r <= nbr_id;
    end
  end

  assign id = id_r;

endmodule

// ----- src/tcpq_chain.sv -----
module tcpq_chain #(
  parameter int DEPTH = tcpq_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcpq_pkg::chain_ctrl_t         ctrl,
  input  logic [tcpq_pkg::ID_WIDTH-1:0] push_id,
  output logic [tcpq_pkg::ID_WIDTH-1:0] head_id,
  output logic [$clog2(DEPTH+1)-1:0]    fill
);
  import tcpq_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic [ID_WIDTH-1:0] cell_id [DEPTH];

  // cell 0 is the head; a pop shifts every cell one place toward it,
  // a push writes the cell just past the last occupied one
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_id[i];
    end else begin : g_mid
      assign nbr = cell_id[i+1];
    end
    tcpq_cell u_cell (
      .clk     (clk),
      .load    (ctrl.push && (fill_r == FILL_W'(i))),
      .shift   (ctrl.pop),
      .push_id (push_id),
      .nbr_id  (nbr),
      .id      (cell_id[i])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctrl.push) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (ctrl.pop) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign head_id = cell_id[0];
  assign fill    = fill_r;

endmodule

// ----- src/two_class_priority_queue_admit.sv -----
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready   | tcpq_pkg::in_item_t  (operation, client_class)
// out_    | output    | out_valid/out_ready | tcpq_pkg::out_item_t (status, client_id, served_class)
// cfg_    | input     | cfg_we, no wait     | cfg_wdata = waiting_limit
//
// Cycles: one transfer per cycle unless stalled; the result appears the cycle after the transfer.
// The limit compare, queue select and head read are all combinational, ahead of the output register.
// Reset (rst_n low, synchronous) empties both queues, zeroes the id counter and
// sets waiting_limit to 5. Cell contents are not reset; fill counts guard them.
// Stalls: a held result blocks input only while out_ready is low.
module two_class_priority_queue_admit #(
  parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tcpq_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tcpq_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [tcpq_pkg::LIMIT_WIDTH-1:0] cfg_wdata
);
  import tcpq_pkg::*;

  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W   = $clog2(2 * QUEUE_DEPTH + 1);
  localparam int CMP_W   = (TOT_W > LIMIT_WIDTH) ? TOT_W : LIMIT_WIDTH;

  // configuration and id counter
  logic [LIMIT_WIDTH-1:0] limit_r;
  logic [ID_WIDTH-1:0]    next_id_r;
  logic [ID_WIDTH-1:0]    next_id_nxt;

  // output register
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  // chain interfaces
  chain_ctrl_t         ord_ctrl;
  chain_ctrl_t         pri_ctrl;
  logic [ID_WIDTH-1:0] ord_head;
  logic [ID_WIDTH-1:0] pri_head;
  logic [FILL_W-1:0]   ord_fill;
  logic [FILL_W-1:0]   pri_fill;

  logic             accept;
  logic [TOT_W-1:0] total;
  logic             own_full;
  logic             admit;

  // the output register refills in the same cycle it is drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign total    = TOT_W'(ord_fill) + TOT_W'(pri_fill);
  assign own_full = (in_data.client_class == CLASS_PRIORITY)
                    ? (pri_fill == FILL_W'(QUEUE_DEPTH))
                    : (ord_fill == FILL_W'(QUEUE_DEPTH));
  // shared tail-drop limit, plus the per-class capacity check
  assign admit    = (CMP_W'(total) < CMP_W'(limit_r)) && !own_full;

  tcpq_chain #(.DEPTH(QUEUE_DEPTH)) u_ord_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ord_ctrl),
    .push_id (next_id_r),
    .head_id (ord_head),
    .fill    (ord_fill)
  );

  tcpq_chain #(.DEPTH(QUEUE_DEPTH)) u_pri_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (pri_ctrl),
    .push_id (next_id_r),
    .head_id (pri_head),
    .fill    (pri_fill)
  );

  always_comb begin
    ord_ctrl      = '0;
    pri_ctrl      = '0;
    next_id_nxt   = next_id_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (accept) begin
      out_valid_nxt = 1'b1;
      case (in_data.operation)
        OP_ARRIVE: begin
          // the id is consumed whether or not the client gets in
          next_id_nxt               = next_id_r + ID_WIDTH'(1);
          out_data_nxt.client_id    = next_id_r;
          out_data_nxt.served_class = in_data.client_class;
          out_data_nxt.status       = admit ? ST_ADMITTED : ST_TURNED_AWAY;
          if (admit && (in_data.client_class == CLASS_PRIORITY)) begin
            pri_ctrl.push = 1'b1;
          end else if (admit) begin
            ord_ctrl.push = 1'b1;
          end
        end
        OP_SERVE: begin
          // strict priority: priority queue drains first
          if (pri_fill != '0) begin
            pri_ctrl.pop              = 1'b1;
            out_data_nxt.status       = ST_SERVED;
            out_data_nxt.client_id    = pri_head;
            out_data_nxt.served_class = CLASS_PRIORITY;
          end else if (ord_fill != '0) begin
            ord_ctrl.pop              = 1'b1;
            out_data_nxt.status       = ST_SERVED;
            out_data_nxt.client_id    = ord_head;
            out_data_nxt.served_class = CLASS_ORDINARY;
          end else begin
            out_data_nxt.status       = ST_EMPTY;
            out_data_nxt.client_id    = '0;
            out_data_nxt.served_class = CLASS_ORDINARY;
          end
        end
        default: begin
          out_data_nxt.status       = ST_EMPTY;
          out_data_nxt.client_id    = '0;
          out_data_nxt.served_class = CLASS_ORDINARY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/tcpq_checker.sv -----
module tcpq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input tcpq_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input tcpq_pkg::out_item_t out_data
);
  import tcpq_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an arrival answers admitted or turned away in the next cycle
  a_arrive_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.operation == OP_ARRIVE) |=>
      out_valid && ((out_data.status == ST_ADMITTED) ||
                    (out_data.status == ST_TURNED_AWAY)))
    else $error("bad response to arrival");

  // a serve answers served or empty in the next cycle
  a_serve_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.operation == OP_SERVE) |=>
      out_valid && ((out_data.status == ST_SERVED) ||
                    (out_data.status == ST_EMPTY)))
    else $error("bad response to serve");

  // empty report carries zero id and class
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |->
      (out_data.client_id == '0) && (out_data.served_class == CLASS_ORDINARY))
    else $error("empty report with nonzero fields");

endmodule

bind two_class_priority_queue_admit tcpq_checker u_tcpq_checker (.*);

// ----- tb/tb_two_class_priority_queue_admit.sv -----
module tb_two_class_priority_queue_admit;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpq_pkg::*;

  localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = HEAD_W + 1;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [LIMIT_WIDTH-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  two_class_priority_queue_admit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  in_item_t  request_q[$];   // requests not yet presented to the DUT
  out_item_t outcome_q[$];   // predicted results, oldest first

  int   sender_idle_pct   = 9;
  int   receiver_idle_pct = 83;
  logic in_fire           = 1'b0;  // input transfer seen at the last rising edge
  logic drain_pause       = 1'b0;  // sender holds off until all results are back
  int   drain_pauses      = 0;
  int   failures          = 0;
  int   tally[4]          = '{0, 0, 0, 0};  // checked results per status
  int   limit_writes      = 0;

  // Predictor state: two rings of ids, their heads and fill counts, the id
  // counter and the shared waiting limit.
  logic [ID_WIDTH-1:0]    ord_ids[QUEUE_DEPTH];
  logic [ID_WIDTH-1:0]    pri_ids[QUEUE_DEPTH];
  logic [HEAD_W-1:0]      ord_head, pri_head;
  logic [COUNT_W-1:0]     ord_count, pri_count;
  logic [ID_WIDTH-1:0]    next_client_id;
  logic [LIMIT_WIDTH-1:0] limit_now;

  // Admit, turn away or serve one request and return the result it gives.
  function automatic out_item_t predict_outcome(in_item_t req);
    out_item_t        res;
    logic [COUNT_W:0] waiting;
    logic [COUNT_W-1:0] own;
    res = '0;
    if (req.operation == OP_ARRIVE) begin
      waiting = ord_count + pri_count;
      own     = (req.client_class == CLASS_PRIORITY) ? pri_count : ord_count;
      res.client_id    = next_client_id;
      res.served_class = req.client_class;
      // the id is used up even when the client is turned away
      next_client_id = next_client_id + 1'b1;
      if (waiting < limit_now && own < QUEUE_DEPTH) begin
        res.status = ST_ADMITTED;
        if (req.client_class == CLASS_PRIORITY) begin
          pri_ids[HEAD_W'(pri_head + pri_count)] = res.client_id;
          pri_count = pri_count + 1'b1;
        end else begin
          ord_ids[HEAD_W'(ord_head + ord_count)] = res.client_id;
          ord_count = ord_count + 1'b1;
        end
      end else begin
        res.status = ST_TURNED_AWAY;
      end
    end else if (pri_count != 0) begin
      // strict priority: the priority ring always goes first
      res.status       = ST_SERVED;
      res.client_id    = pri_ids[pri_head];
      res.served_class = CLASS_PRIORITY;
      pri_head  = pri_head + 1'b1;
      pri_count = pri_count - 1'b1;
    end else if (ord_count != 0) begin
      res.status       = ST_SERVED;
      res.client_id    = ord_ids[ord_head];
      res.served_class = CLASS_ORDINARY;
      ord_head  = ord_head + 1'b1;
      ord_count = ord_count - 1'b1;
    end else begin
      res.status = ST_EMPTY;  // id and class stay zero
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= 50)
        $display("t=%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and predictor, on the rising edge. The result transfer is checked
  // before the input transfer of the same edge is predicted, so an early
  // result can never be matched against its own expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    in_fire <= rst_n && in_valid && in_ready;
    if (!rst_n) begin
      ord_head       = '0;
      pri_head       = '0;
      ord_count      = '0;
      pri_count      = '0;
      next_client_id = '0;
      limit_now      = LIMIT_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          failures++;
          if (failures <= 50)
            $display("t=%0t: result with nothing expected, expected none, actual %0d/%0d/%0d",
                     $time, out_data.status, out_data.client_id, out_data.served_class);
        end else begin
          want = outcome_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("client_id", 32'(want.client_id), 32'(out_data.client_id));
          check_field("served_class", 32'(want.served_class), 32'(out_data.served_class));
          tally[want.status]++;
        end
      end
      if (in_valid && in_ready)
        outcome_q.push_back(predict_outcome(in_data));
    end
  end

  // ---------------------------------------------------------------------------
  // Driver, on the falling edge. A presented request holds until its transfer;
  // then the next one goes out unless the sender idles or waits for a drain.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (drain_pause && outcome_q.size() == 0)
        drain_pause = 1'b0;
      if (!drain_pause && request_q.size() != 0 && $urandom_range(0, 199) == 0) begin
        drain_pause = 1'b1;
        drain_pauses++;
      end
      if (!drain_pause && request_q.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure, also on the falling edge.
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_request(op_t op, logic cls);
    in_item_t req;
    req.operation    = op;
    req.client_class = cls;
    request_q.push_back(req);
  endtask

  // Idle means: nothing queued, nothing presented, every result back.
  task automatic wait_until_drained();
    do begin
      @(posedge clk);
      #1;
    end while (request_q.size() != 0 || in_valid || outcome_q.size() != 0);
  endtask

  // Only called while the block is idle; the model follows the same edge.
  task automatic write_limit(int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LIMIT_WIDTH'(value);
    limit_now = LIMIT_WIDTH'(value);
    limit_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly fill-then-drain bursts so the rings hit the limit, wrap and empty
  // out; about one burst in ten is a short random mix instead.
  task automatic queue_traffic(int n_items, int cap);
    int made, n_arr, n_srv, mode;
    made = 0;
    if (cap > QUEUE_DEPTH) begin
      // limit above ring capacity: one class runs into its own full ring
      repeat (20) add_request(OP_ARRIVE, CLASS_PRIORITY);
      repeat (20) add_request(OP_ARRIVE, CLASS_ORDINARY);
      repeat (42) add_request(OP_SERVE, 1'($urandom_range(0, 1)));
      made = 82;
    end
    while (made < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        n_arr = $urandom_range(1, 8);
        repeat (n_arr) add_request(op_t'(1'($urandom_range(0, 1))), 1'($urandom_range(0, 1)));
        made += n_arr;
      end else begin
        mode  = $urandom_range(0, 2);
        n_arr = $urandom_range(1, cap + 3);
        repeat (n_arr)
          add_request(OP_ARRIVE, (mode == 2) ? 1'($urandom_range(0, 1)) : 1'(mode));
        n_srv = $urandom_range(1, n_arr + 2);
        repeat (n_srv) add_request(OP_SERVE, 1'($urandom_range(0, 1)));
        made += n_arr + n_srv;
      end
    end
  endtask

  task automatic limit_phase(int value, int n_items);
    write_limit(value);
    queue_traffic(n_items, value);
    wait_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, limit at its reset value of 5.
    add_request(OP_SERVE, CLASS_ORDINARY);   // serve with both rings empty
    add_request(OP_SERVE, CLASS_PRIORITY);   // class bit ignored on serve
    add_request(OP_ARRIVE, CLASS_ORDINARY);
    add_request(OP_ARRIVE, CLASS_PRIORITY);
    add_request(OP_ARRIVE, CLASS_ORDINARY);
    add_request(OP_ARRIVE, CLASS_PRIORITY);
    add_request(OP_ARRIVE, CLASS_ORDINARY);  // five waiting: at the limit
    add_request(OP_ARRIVE, CLASS_PRIORITY);  // turned away, id still used
    add_request(OP_ARRIVE, CLASS_ORDINARY);  // turned away
    repeat (5) add_request(OP_SERVE, CLASS_ORDINARY);  // priority pair first
    add_request(OP_SERVE, CLASS_PRIORITY);   // empty again
    wait_until_drained();

    // Limit of zero turns every arrival away.
    write_limit(0);
    add_request(OP_ARRIVE, CLASS_ORDINARY);
    add_request(OP_ARRIVE, CLASS_PRIORITY);
    add_request(OP_SERVE, CLASS_ORDINARY);
    wait_until_drained();

    // Slow receiver.
    sender_idle_pct   = 9;
    receiver_idle_pct = 83;
    limit_phase(31, 190);
    limit_phase(1, 190);
    limit_phase(16, 190);

    // Slow sender.
    sender_idle_pct   = 83;
    receiver_idle_pct = 9;
    limit_phase(16, 190);
    limit_phase($urandom_range(0, 31), 190);
    limit_phase(2, 190);

    // Back to back.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    limit_phase(31, 190);
    limit_phase($urandom_range(0, 31), 190);
    limit_phase(5, 190);

    // extra edges catch any stray result
    repeat (8) @(posedge clk);
    #1;
    if (outcome_q.size() != 0) begin
      failures++;
      $display("t=%0t: %0d results never arrived, expected 0 left, actual %0d",
               $time, outcome_q.size(), outcome_q.size());
    end

    $display("Checked %0d admitted, %0d turned away, %0d served, %0d empty results",
             tally[ST_ADMITTED], tally[ST_TURNED_AWAY], tally[ST_SERVED], tally[ST_EMPTY]);
    $display("over %0d limit writes and %0d drain pauses", limit_writes, drain_pauses);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
